// ----- rtl/mfd_pkg.sv -----
// ----------------------------------------------------------------------------
// mfd_pkg: shared types and constants of the modulated feedback delay
// Sizes, register codes and reset values, the queue item and the sine table.
// ----------------------------------------------------------------------------
package mfd_pkg;

  localparam int STORE_DEPTH  = 131072;
  localparam int SAMPLE_BITS  = 16;
  localparam int SINE_ENTRIES = 256;
  localparam int QUEUE_DEPTH  = 2;

  localparam int PTR_W = $clog2(STORE_DEPTH);
  localparam int LEN_W = PTR_W + 1;
  localparam int IDX_W = $clog2(SINE_ENTRIES);

  // fixed register widths
  localparam int BLEN_W  = 18;
  localparam int BASE_W  = 26;
  localparam int GAIN_W  = 16;
  localparam int DEPTH_W = 16;
  localparam int STEP_W  = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BUFFER_LENGTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_DELAY     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FEEDBACK_GAIN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WOW_DEPTH      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FLUTTER_DEPTH  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_WOW_STEP       = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_FLUTTER_STEP   = 3'd6;

  // reset values
  localparam logic [BLEN_W-1:0]  RST_BUFFER_LENGTH = 18'd131072;
  localparam logic [BASE_W-1:0]  RST_BASE_DELAY    = 26'd6144000;
  localparam logic [GAIN_W-1:0]  RST_FEEDBACK_GAIN = 16'd19661;
  localparam logic [DEPTH_W-1:0] RST_DEPTH         = 16'd0;
  localparam logic [STEP_W-1:0]  RST_WOW_STEP      = 32'd89478;
  localparam logic [STEP_W-1:0]  RST_FLUTTER_STEP  = 32'd715828;

  localparam logic [63:0] PI_Q30 = 64'd3373259426;

  typedef struct packed {
    logic [LEN_W-1:0]   len;          // clamped to 2..STORE_DEPTH
    logic [BASE_W-1:0]  base_delay;
    logic [GAIN_W-1:0]  feedback_gain;
    logic [DEPTH_W-1:0] wow_depth;
    logic [DEPTH_W-1:0] flutter_depth;
    logic [STEP_W-1:0]  wow_step;
    logic [STEP_W-1:0]  flutter_step;
  } cfg_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic [PTR_W-1:0]              delay;
  } qitem_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  typedef logic [15:0] sine_tab_t [0:SINE_ENTRIES];

  // quarter-wave sine in Q1.15, Taylor series in Q30, evaluated at elaboration
  function automatic sine_tab_t build_sine();
    sine_tab_t   tab;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] sum;
    logic [63:0] term;
    logic [63:0] q;
    for (int i = 0; i <= SINE_ENTRIES; i++) begin
      x    = (64'(i) * PI_Q30) / 64'(2 * SINE_ENTRIES);
      x2   = (x * x) >> 30;
      sum  = x;
      term = x;
      for (int k = 1; k <= 7; k++) begin
        term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
        if ((k & 1) == 1) begin
          sum = sum - term;
        end else begin
          sum = sum + term;
        end
      end
      q = (sum + 64'd16384) >> 15;
      if (q > 64'd32767) begin
        q = 64'd32767;
      end
      tab[i] = q[15:0];
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE_TAB = build_sine();

endpackage

// ----- rtl/modulated_feedback_delay_unit.sv -----
// ----------------------------------------------------------------------------
// modulated_feedback_delay_unit: tape-style feedback delay with wow/flutter
// Top level: configuration registers, front, item queue and back.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o, sample_in_i) takes one Q1.15
//   sample per item; output channel (out_valid_o/out_ready_i,
//   delayed_sample_o) returns one delayed sample per item, in order.
//   Config channel (cfg_valid_i/cfg_ready_o, cfg_index_i, cfg_data_i) is
//   always ready; write it only while the block is idle.
//   Sequencing: the front sequencer steps through accept, sine lookup,
//   depth multiply and delay sum/clamp for each item and takes no new
//   item before it is through. The back (store read, feedback multiply,
//   store write) keeps up; the output register loads at the store write.
//   Reset: registers take their reset values, phases and write pointer go
//   to zero. The store is not swept; a fill count makes entries never
//   written read as zero, so items are taken right after reset.
//   Stall: the output register holds its item, the back waits before its
//   store write, the 2-entry queue fills and then the front stops taking
//   input items.
// ----------------------------------------------------------------------------
module modulated_feedback_delay_unit import mfd_pkg::*; (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]          cfg_index_i,
  input  logic [CFG_DATA_W-1:0]         cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [SAMPLE_BITS-1:0] sample_in_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [SAMPLE_BITS-1:0] delayed_sample_o
);

  // configuration registers
  logic [BLEN_W-1:0]  buffer_length_q;
  logic [BASE_W-1:0]  base_delay_q;
  logic [GAIN_W-1:0]  feedback_gain_q;
  logic [DEPTH_W-1:0] wow_depth_q;
  logic [DEPTH_W-1:0] flutter_depth_q;
  logic [STEP_W-1:0]  wow_step_q;
  logic [STEP_W-1:0]  flutter_step_q;

  cfg_t   cfg;
  qstat_t q_stat;
  qitem_t q_push_item, q_pop_item;
  logic   q_push, q_pop;
  logic   cfg_we;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buffer_length_q <= RST_BUFFER_LENGTH;
      base_delay_q    <= RST_BASE_DELAY;
      feedback_gain_q <= RST_FEEDBACK_GAIN;
      wow_depth_q     <= RST_DEPTH;
      flutter_depth_q <= RST_DEPTH;
      wow_step_q      <= RST_WOW_STEP;
      flutter_step_q  <= RST_FLUTTER_STEP;
    end else if (cfg_we) begin
      case (cfg_index_i)
        REG_BUFFER_LENGTH: buffer_length_q <= cfg_data_i[BLEN_W-1:0];
        REG_BASE_DELAY:    base_delay_q    <= cfg_data_i[BASE_W-1:0];
        REG_FEEDBACK_GAIN: feedback_gain_q <= cfg_data_i[GAIN_W-1:0];
        REG_WOW_DEPTH:     wow_depth_q     <= cfg_data_i[DEPTH_W-1:0];
        REG_FLUTTER_DEPTH: flutter_depth_q <= cfg_data_i[DEPTH_W-1:0];
        REG_WOW_STEP:      wow_step_q      <= cfg_data_i[STEP_W-1:0];
        REG_FLUTTER_STEP:  flutter_step_q  <= cfg_data_i[STEP_W-1:0];
        default: ;  // unmapped index: ignored
      endcase
    end
  end

  // length in use: below 2 acts as 2, above the store acts as the store size
  always_comb begin
    if (32'(buffer_length_q) > 32'(STORE_DEPTH)) begin
      cfg.len = LEN_W'(STORE_DEPTH);
    end else if (buffer_length_q < BLEN_W'(2)) begin
      cfg.len = LEN_W'(2);
    end else begin
      cfg.len = LEN_W'(buffer_length_q);
    end
    cfg.base_delay    = base_delay_q;
    cfg.feedback_gain = feedback_gain_q;
    cfg.wow_depth     = wow_depth_q;
    cfg.flutter_depth = flutter_depth_q;
    cfg.wow_step      = wow_step_q;
    cfg.flutter_step  = flutter_step_q;
  end

  // front: phases, sine, delay in whole samples
  mfd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .sample_in_i (sample_in_i),
    .q_stat_i    (q_stat),
    .push_o      (q_push),
    .push_item_o (q_push_item)
  );

  // item queue decouples front and back
  mfd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_item_i (q_push_item),
    .pop_i       (q_pop),
    .pop_item_o  (q_pop_item),
    .stat_o      (q_stat)
  );

  // back: store read, feedback write, output register
  mfd_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg),
    .q_stat_i         (q_stat),
    .pop_item_i       (q_pop_item),
    .pop_o            (q_pop),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .delayed_sample_o (delayed_sample_o)
  );

  // front never pushes into a full queue
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_stat.full |-> !q_push)
    else $error("queue push while full");

  // back never pops an empty queue
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_stat.empty |-> !q_pop)
    else $error("queue pop while empty");

  // an accepted item keeps the front busy in the next cycle
  a_front_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("front took items back to back");

endmodule

// ----- rtl/mfd_ram.sv -----
// ----------------------------------------------------------------------------
// mfd_ram: generic single-clock RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module mfd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ----- rtl/mfd_queue.sv -----
// ----------------------------------------------------------------------------
// mfd_queue: short item queue between front and back
// Flop-based FIFO, first-word fall-through read.
// ----------------------------------------------------------------------------
module mfd_queue import mfd_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  qitem_t push_item_i,
  input  logic   pop_i,
  output qitem_t pop_item_o,
  output qstat_t stat_o
);

  localparam int QP_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QC_W = $clog2(QUEUE_DEPTH + 1);

  qitem_t           mem_q [QUEUE_DEPTH];
  logic [QP_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [QP_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [QC_W-1:0]  count_q, count_d;

  function automatic logic [QP_W-1:0] ptr_inc(logic [QP_W-1:0] p);
    logic [QP_W-1:0] r;
    if (p == QP_W'(QUEUE_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + 1'b1;
    end
    return r;
  endfunction

  assign pop_item_o   = mem_q[rd_ptr_q];
  assign stat_o.full  = (count_q == QC_W'(QUEUE_DEPTH));
  assign stat_o.empty = (count_q == '0);

  always_comb begin
    wr_ptr_d = push_i ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i  ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

// ----- rtl/mfd_front.sv -----
// ----------------------------------------------------------------------------
// mfd_front: input side, oscillators and delay computation
// Advances wow/flutter phases, looks up sine, scales, floors and clamps.
// ----------------------------------------------------------------------------
module mfd_front import mfd_pkg::*; (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  cfg_t                          cfg_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [SAMPLE_BITS-1:0] sample_in_i,
  input  qstat_t                        q_stat_i,
  output logic                          push_o,
  output qitem_t                        push_item_o
);

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_LOOK = 2'd1;
  localparam logic [1:0] F_MUL  = 2'd2;
  localparam logic [1:0] F_SUM  = 2'd3;

  localparam int SV_W  = 17;                  // signed sine value
  localparam int PR_W  = SV_W + DEPTH_W + 1;  // sine times depth
  localparam int TOT_W = BASE_W + 15 + 2;
  localparam int CMP_W = 32;

  logic [1:0]                    state_q, state_d;
  logic [STEP_W-1:0]             wow_phase_q, flutter_phase_q;
  logic signed [SAMPLE_BITS-1:0] sample_q;
  logic signed [SV_W-1:0]        sw_q, sf_q;
  logic signed [PR_W-1:0]        pw_q, pf_q;
  logic signed [TOT_W-1:0]       total;
  logic [CMP_W-1:0]              whole, len_m1, dly;
  logic                          accept;

  function automatic logic signed [SV_W-1:0] sine_of(logic [STEP_W-1:0] ph);
    logic [IDX_W:0]  idx;
    logic [15:0]     v;
    idx = {1'b0, ph[29 -: IDX_W]};
    if (ph[30]) begin
      idx = (IDX_W + 1)'(SINE_ENTRIES) - idx;
    end
    v = SINE_TAB[idx];
    return ph[31] ? -$signed({1'b0, v}) : $signed({1'b0, v});
  endfunction

  assign in_ready_o = (state_q == F_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign push_o     = (state_q == F_SUM) && !q_stat_i.full;

  // delay in 1/256 samples, Q15-scaled; floor by 2^23 gives whole samples
  always_comb begin
    total  = $signed({2'b00, cfg_i.base_delay, 15'b0}) + TOT_W'(pw_q) + TOT_W'(pf_q);
    whole  = CMP_W'(total[TOT_W-2:23]);
    len_m1 = CMP_W'(cfg_i.len) - 1'b1;
    if (total[TOT_W-1] || whole == '0) begin
      dly = CMP_W'(1);
    end else if (whole > len_m1) begin
      dly = len_m1;
    end else begin
      dly = whole;
    end
    push_item_o.sample = sample_q;
    push_item_o.delay  = dly[PTR_W-1:0];
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      F_IDLE:  if (accept) state_d = F_LOOK;
      F_LOOK:  state_d = F_MUL;
      F_MUL:   state_d = F_SUM;
      F_SUM:   if (push_o) state_d = F_IDLE;
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= F_IDLE;
      wow_phase_q     <= '0;
      flutter_phase_q <= '0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        wow_phase_q     <= wow_phase_q + cfg_i.wow_step;
        flutter_phase_q <= flutter_phase_q + cfg_i.flutter_step;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      sample_q <= sample_in_i;
    end
    if (state_q == F_LOOK) begin
      sw_q <= sine_of(wow_phase_q);
      sf_q <= sine_of(flutter_phase_q);
    end
    if (state_q == F_MUL) begin
      pw_q <= PR_W'(sw_q) * PR_W'($signed({1'b0, cfg_i.wow_depth}));
      pf_q <= PR_W'(sf_q) * PR_W'($signed({1'b0, cfg_i.flutter_depth}));
    end
  end

endmodule

// ----- rtl/mfd_back.sv -----
// ----------------------------------------------------------------------------
// mfd_back: delay store access and feedback
// Reads the delayed sample, writes input plus feedback, drives the output.
// ----------------------------------------------------------------------------
module mfd_back import mfd_pkg::*; (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  cfg_t                          cfg_i,
  input  qstat_t                        q_stat_i,
  input  qitem_t                        pop_item_i,
  output logic                          pop_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [SAMPLE_BITS-1:0] delayed_sample_o
);

  localparam logic [1:0] B_IDLE  = 2'd0;
  localparam logic [1:0] B_READ  = 2'd1;
  localparam logic [1:0] B_WRITE = 2'd2;

  localparam int FB_W   = SAMPLE_BITS + GAIN_W + 1;
  localparam int RP_W   = LEN_W + 1;
  localparam int SUM_W  = SAMPLE_BITS + 2;
  localparam logic signed [SAMPLE_BITS-1:0] SMAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SMIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  logic [1:0]                    state_q, state_d;
  logic [PTR_W-1:0]              wp_q;
  logic [LEN_W-1:0]              fill_q;      // entries 0..fill-1 have been written
  logic signed [SAMPLE_BITS-1:0] sample_q, delayed_q, out_q;
  logic                          rd_ok_q, out_valid_q;
  logic signed [FB_W-1:0]        prod_q;
  logic [RP_W-1:0]               rp_full;
  logic [PTR_W-1:0]              rp;
  logic [SAMPLE_BITS-1:0]        rdata;
  logic signed [SAMPLE_BITS-1:0] delayed;
  logic signed [SUM_W-1:0]       wsum;
  logic signed [SAMPLE_BITS-1:0] wsat;
  logic [LEN_W-1:0]              wp_next;
  logic                          advance;

  assign pop_o   = (state_q == B_IDLE) && !q_stat_i.empty;
  assign advance = (state_q == B_WRITE) && (!out_valid_q || out_ready_i);

  // read position behind the write pointer, wrapping by the length
  always_comb begin
    if (wp_q >= pop_item_i.delay) begin
      rp_full = RP_W'(wp_q) - RP_W'(pop_item_i.delay);
    end else begin
      rp_full = RP_W'(wp_q) + RP_W'(cfg_i.len) - RP_W'(pop_item_i.delay);
    end
    if (rp_full >= RP_W'(STORE_DEPTH)) begin
      rp = '0;
    end else begin
      rp = rp_full[PTR_W-1:0];
    end
  end

  assign delayed = rd_ok_q ? $signed(rdata) : '0;

  // feedback floored by 2^16, added and saturated
  always_comb begin
    wsum = SUM_W'(sample_q) + SUM_W'($signed(prod_q[FB_W-1:GAIN_W]));
    if (wsum > SUM_W'(SMAX)) begin
      wsat = SMAX;
    end else if (wsum < SUM_W'(SMIN)) begin
      wsat = SMIN;
    end else begin
      wsat = wsum[SAMPLE_BITS-1:0];
    end
    wp_next = LEN_W'(wp_q) + 1'b1;
    if (wp_next >= cfg_i.len) begin
      wp_next = '0;
    end
  end

  mfd_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (advance),
    .waddr_i (wp_q),
    .wdata_i (wsat),
    .re_i    (pop_o),
    .raddr_i (rp),
    .rdata_o (rdata)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      B_IDLE:  if (pop_o) state_d = B_READ;
      B_READ:  state_d = B_WRITE;
      B_WRITE: if (advance) state_d = B_IDLE;
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      wp_q        <= '0;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (advance) begin
        wp_q <= wp_next[PTR_W-1:0];
        if (LEN_W'(wp_q) == fill_q && fill_q != LEN_W'(STORE_DEPTH)) begin
          fill_q <= fill_q + 1'b1;
        end
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      sample_q <= pop_item_i.sample;
      rd_ok_q  <= (LEN_W'(rp) < fill_q);
    end
    if (state_q == B_READ) begin
      delayed_q <= delayed;
      prod_q    <= FB_W'(delayed) * FB_W'($signed({1'b0, cfg_i.feedback_gain}));
    end
    if (advance) begin
      out_q <= delayed_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign delayed_sample_o = out_q;

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for modulated_feedback_delay_unit
// A directed table covers reset state, store length and delay extremes,
// negative delay sums and feedback saturation. Random phases follow, each
// with new register settings. Each delayed sample is checked against a typed
// value or an in-bench delay line model; both handshakes stall at random but in the first phase.
// ----------------------------------------------------------------------------
module tb;
  import mfd_pkg::*;

  typedef logic signed [SAMPLE_BITS-1:0] pcm_t;
  typedef longint unsigned u64_t;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;  // outside the register map
  localparam longint PCM_MAX       = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
  localparam longint PCM_MIN       = -PCM_MAX - 1;
  localparam int     STALL_LIMIT   = 4000;
  localparam int     RUN_PHASES    = 10;
  localparam int     PHASE_SAMPLES = 70;
  localparam int     MAX_REPORTS   = 200;

  typedef enum logic {ROW_WRITE, ROW_SAMPLE} row_kind_e;

  typedef struct packed {
    row_kind_e            kind;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [CFG_DATA_W-1:0] reg_val;
    pcm_t                 sample;
    logic                 typed;   // want below is read off by hand
    pcm_t                 want;
  } row_t;

  // DUT connections
  logic                  clk;
  logic                  rst_n     = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  pcm_t                  sample_in = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  pcm_t                  delayed_sample;

  // typed expectation travels with the item, updated with the same edge
  logic typed_row  = 1'b0;
  pcm_t typed_want = '0;

  // delay line model state
  int                 sine_q15 [0:SINE_ENTRIES];
  pcm_t               dly_mem  [STORE_DEPTH];
  int unsigned        wr_ptr;
  logic [STEP_W-1:0]  wow_ph, flut_ph;
  logic [BLEN_W-1:0]  r_len        = RST_BUFFER_LENGTH;
  logic [BASE_W-1:0]  r_base       = RST_BASE_DELAY;
  logic [GAIN_W-1:0]  r_gain       = RST_FEEDBACK_GAIN;
  logic [DEPTH_W-1:0] r_wow_depth  = RST_DEPTH;
  logic [DEPTH_W-1:0] r_flut_depth = RST_DEPTH;
  logic [STEP_W-1:0]  r_wow_step   = RST_WOW_STEP;
  logic [STEP_W-1:0]  r_flut_step  = RST_FLUTTER_STEP;

  pcm_t expected_taps [$];
  row_t opening [$];

  bit no_idle = 1'b0;
  int n_samples, n_writes, n_checked, n_clipped, n_err, stall_cycles;

  modulated_feedback_delay_unit dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .sample_in_i      (sample_in),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .delayed_sample_o (delayed_sample)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------- model --

  // Q1.15 quarter wave, Taylor series evaluated in Q30
  function automatic void build_quarter_wave();
    u64_t ang, ang_sq, acc, tm;
    for (u64_t i = 0; i <= SINE_ENTRIES; i++) begin
      ang    = (i * PI_Q30) / u64_t'(2 * SINE_ENTRIES);
      ang_sq = (ang * ang) >> 30;
      acc    = ang;
      tm     = ang;
      for (int k = 1; k <= 7; k++) begin
        tm  = ((tm * ang_sq) >> 30) / u64_t'((2 * k) * (2 * k + 1));
        acc = (k % 2 == 1) ? acc - tm : acc + tm;
      end
      acc = (acc + u64_t'(16384)) >> 15;
      sine_q15[i] = (acc > u64_t'(32767)) ? 32767 : int'(acc);
    end
  endfunction

  // quadrant from the top two phase bits, table index from the next eight
  function automatic longint osc_value(input logic [STEP_W-1:0] ph);
    int unsigned pos;
    pos = 32'(ph[29:22]);
    if (ph[30]) begin
      pos = SINE_ENTRIES - pos;
    end
    return ph[31] ? -longint'(sine_q15[pos]) : longint'(sine_q15[pos]);
  endfunction

  function automatic void load_reg(input logic [CFG_IDX_W-1:0] idx,
                                   input logic [CFG_DATA_W-1:0] val);
    case (idx)
      REG_BUFFER_LENGTH: r_len        = val[BLEN_W-1:0];
      REG_BASE_DELAY:    r_base       = val[BASE_W-1:0];
      REG_FEEDBACK_GAIN: r_gain       = val[GAIN_W-1:0];
      REG_WOW_DEPTH:     r_wow_depth  = val[DEPTH_W-1:0];
      REG_FLUTTER_DEPTH: r_flut_depth = val[DEPTH_W-1:0];
      REG_WOW_STEP:      r_wow_step   = val;
      REG_FLUTTER_STEP:  r_flut_step  = val;
      default: ;
    endcase
  endfunction

  // one sample through the delay line; returns the tap that was read
  function automatic pcm_t delay_line_step(input pcm_t x);
    int unsigned eff_len, taps, rd, wr;
    longint      sum_q23, fb, mixed;
    pcm_t        tap;
    wow_ph  = wow_ph + r_wow_step;
    flut_ph = flut_ph + r_flut_step;
    eff_len = (r_len < 2) ? 2 : ((r_len > STORE_DEPTH) ? STORE_DEPTH : r_len);
    sum_q23 = longint'(r_base) * 32768
            + osc_value(wow_ph) * longint'(r_wow_depth)
            + osc_value(flut_ph) * longint'(r_flut_depth);
    taps = (sum_q23 <= 0) ? 0 : int'(sum_q23 >>> 23);
    if (taps < 1) begin
      taps = 1;
    end
    if (taps > eff_len - 1) begin
      taps = eff_len - 1;
    end
    // pointer may sit past a shrunk length; read still wraps by the length
    wr = wr_ptr;
    rd = (wr >= taps) ? wr - taps : wr + eff_len - taps;
    if (rd >= STORE_DEPTH) begin
      rd = 0;
    end
    tap   = dly_mem[rd];
    fb    = (longint'(tap) * longint'(r_gain)) >>> 16;  // floor
    mixed = longint'(x) + fb;
    if (mixed > PCM_MAX || mixed < PCM_MIN) begin
      n_clipped++;
      mixed = (mixed > PCM_MAX) ? PCM_MAX : PCM_MIN;
    end
    dly_mem[wr] = pcm_t'(mixed);
    wr_ptr = (wr + 1 >= eff_len) ? 0 : wr + 1;
    return tap;
  endfunction

  // -------------------------------------------------------------- monitor --

  always @(posedge clk) begin : monitor
    pcm_t tap;
    pcm_t want;
    if (rst_n) begin
      stall_cycles++;
      if (cfg_valid && cfg_ready) begin
        load_reg(cfg_index, cfg_data);
        n_writes++;
        stall_cycles = 0;
      end
      if (in_valid && in_ready) begin
        tap = delay_line_step(sample_in);
        expected_taps.push_back(typed_row ? typed_want : tap);
        n_samples++;
        stall_cycles = 0;
      end
      if (out_valid && out_ready) begin
        stall_cycles = 0;
        if (expected_taps.size() == 0) begin
          n_err++;
          if (n_err <= MAX_REPORTS) begin
            $display("%0t: delayed_sample %0d arrived with no item pending",
                     $time, delayed_sample);
          end
        end else begin
          want = expected_taps.pop_front();
          n_checked++;
          if (delayed_sample !== want) begin
            n_err++;
            if (n_err <= MAX_REPORTS) begin
              $display("%0t: delayed_sample expected %0d, got %0d",
                       $time, want, delayed_sample);
            end
          end
        end
      end
    end
  end

  // receiver drops ready at random, about 8% of the time, unless no_idle is set
  always @(posedge clk) begin
    out_ready <= no_idle || ($urandom_range(99) >= 8);
  end

  initial begin
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk);
    end
    $display("timeout: %0d cycles without a handshake, %0d items pending",
             STALL_LIMIT, expected_taps.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // ------------------------------------------------------------- stimulus --

  function automatic void add_write(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] val);
    opening.push_back({ROW_WRITE, idx, val, pcm_t'(0), 1'b0, pcm_t'(0)});
  endfunction

  function automatic void add_sample(input pcm_t s, input logic typed, input pcm_t want);
    opening.push_back({ROW_SAMPLE, REG_UNUSED, 32'd0, s, typed, want});
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic push_sample(input pcm_t s, input logic typed, input pcm_t want);
    while (!no_idle && $urandom_range(99) < 8) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    sample_in  <= s;
    typed_row  <= typed;
    typed_want <= want;
    do @(posedge clk); while (!in_ready);
  endtask

  // stop sending and let every pending item come back; the first edge lets
  // the monitor log an item taken at the current edge
  task automatic quiesce();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_taps.size() != 0) begin
      @(posedge clk);
    end
    repeat (8) @(posedge clk);
  endtask

  function automatic pcm_t random_pcm();
    int unsigned pick;
    pick = $urandom_range(9);
    if (pick < 6) begin
      return pcm_t'($urandom);
    end else if (pick < 9) begin
      return pcm_t'(int'($urandom_range(2000)) - 1000);
    end
    return $urandom_range(1) ? pcm_t'(PCM_MAX) : pcm_t'(PCM_MIN);
  endfunction

  initial begin
    bit          line_busy;
    int unsigned pick, len_cfg, span;
    logic [CFG_DATA_W-1:0] v;

    build_quarter_wave();
    foreach (dly_mem[i]) begin
      dly_mem[i] = '0;
    end
    wr_ptr  = 0;
    wow_ph  = '0;
    flut_ph = '0;

    // Reset state: 24000-sample delay over an empty store reads zeros.
    add_sample(16'sh7FFF, 1'b1, 16'sd0);
    add_sample(16'sh8000, 1'b1, 16'sd0);
    add_sample(16'sd0,    1'b1, 16'sd0);
    add_sample(16'sd1,    1'b1, 16'sd0);
    add_sample(-16'sd1,   1'b1, 16'sd0);
    // Shortest length while the pointer sits past it, then length 0 that acts
    // as 2.
    add_write(REG_BUFFER_LENGTH, 32'd2);
    add_sample(16'sd100,  1'b0, 16'sd0);
    add_sample(-16'sd200, 1'b0, 16'sd0);
    add_write(REG_BUFFER_LENGTH, 32'd0);
    add_sample(16'sd300,  1'b0, 16'sd0);
    add_sample(16'sd400,  1'b0, 16'sd0);
    // Gain above 0.95 with zero base delay: store saturates both ways.
    add_write(REG_FEEDBACK_GAIN, 32'hFFFF);
    add_write(REG_BASE_DELAY, 32'd0);
    add_sample(16'sh7FFF, 1'b0, 16'sd0);
    add_sample(16'sh7FFF, 1'b0, 16'sd0);
    add_sample(16'sh7FFF, 1'b0, 16'sd0);
    add_sample(16'sh8000, 1'b0, 16'sd0);
    add_sample(16'sh8000, 1'b0, 16'sd0);
    // Length above the store and the largest base delay: clamp to length-1.
    add_write(REG_BUFFER_LENGTH, 32'h3FFFF);
    add_write(REG_BASE_DELAY, 32'h3FFFFFF);
    add_sample(16'sd5,    1'b0, 16'sd0);
    add_sample(16'sh8000, 1'b0, 16'sd0);
    // Full depth swings on a zero base: sum goes negative, delay clamps to 1.
    add_write(REG_BUFFER_LENGTH, 32'd1);
    add_write(REG_BASE_DELAY, 32'd0);
    add_write(REG_WOW_DEPTH, 32'hFFFF);
    add_write(REG_FLUTTER_DEPTH, 32'hFFFF);
    add_write(REG_WOW_STEP, 32'hFFFF_FFFF);
    add_write(REG_FLUTTER_STEP, 32'h4000_0000);
    add_sample(16'sd7,    1'b0, 16'sd0);
    add_sample(-16'sd7,   1'b0, 16'sd0);
    add_sample(16'sd9,    1'b0, 16'sd0);
    // Short line with modulation around 8 samples and no feedback.
    add_write(REG_BUFFER_LENGTH, 32'd16);
    add_write(REG_BASE_DELAY, 32'd2048);
    add_write(REG_FEEDBACK_GAIN, 32'd0);
    add_write(REG_UNUSED, 32'hDEAD_BEEF);
    add_sample(16'sd1234, 1'b0, 16'sd0);
    add_sample(16'sd2345, 1'b0, 16'sd0);
    add_sample(16'sd3456, 1'b0, 16'sd0);
    add_sample(16'sd4567, 1'b0, 16'sd0);

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    line_busy = 1'b0;
    foreach (opening[i]) begin
      if (opening[i].kind == ROW_WRITE) begin
        if (line_busy) begin
          quiesce();
          line_busy = 1'b0;
        end
        write_reg(opening[i].reg_idx, opening[i].reg_val);
      end else begin
        push_sample(opening[i].sample, opening[i].typed, opening[i].want);
        line_busy = 1'b1;
      end
    end

    for (int ph = 0; ph < RUN_PHASES; ph++) begin
      quiesce();
      no_idle = (ph == 0);  // first phase runs with no stalls at all

      pick = $urandom_range(9);
      if (pick == 0) begin
        len_cfg = $urandom_range(3);
      end else if (pick <= 5) begin
        len_cfg = $urandom_range(64, 4);
      end else if (pick <= 7) begin
        len_cfg = $urandom_range(3000, 65);
      end else if (pick == 8) begin
        len_cfg = STORE_DEPTH;
      end else begin
        len_cfg = $urandom;
      end
      write_reg(REG_BUFFER_LENGTH, len_cfg);

      span = len_cfg % (1 << BLEN_W);
      span = (span < 2) ? 2 : ((span > STORE_DEPTH) ? STORE_DEPTH : span);
      v = ($urandom_range(4) == 0) ? $urandom : $urandom_range(span * 256 + 1024);
      write_reg(REG_BASE_DELAY, v);

      v = ($urandom_range(4) == 0) ? $urandom_range(65535, 62260) : $urandom_range(62259);
      write_reg(REG_FEEDBACK_GAIN, v);
      write_reg(REG_WOW_DEPTH, ($urandom_range(4) == 0) ? 32'd0 : $urandom);
      write_reg(REG_FLUTTER_DEPTH, ($urandom_range(4) == 0) ? 32'd0 : $urandom);

      for (int k = 0; k < 2; k++) begin
        pick = $urandom_range(5);
        if (pick == 0) begin
          v = 32'd0;
        end else if (pick == 1) begin
          v = 32'h8000_0000;
        end else if (pick == 2) begin
          v = $urandom_range(1 << 24);
        end else begin
          v = $urandom;
        end
        write_reg((k == 0) ? REG_WOW_STEP : REG_FLUTTER_STEP, v);
      end

      for (int n = 0; n < PHASE_SAMPLES; n++) begin
        // one mid-phase hold until the line has fully drained
        if (ph == RUN_PHASES / 2 && n == PHASE_SAMPLES / 2) begin
          quiesce();
        end
        push_sample(random_pcm(), 1'b0, 16'sd0);
      end
    end

    quiesce();
    repeat (20) @(posedge clk);

    $display("%0d samples, %0d register writes over %0d random settings plus directed rows",
             n_samples, n_writes, RUN_PHASES);
    $display("%0d delayed samples checked, %0d store writes saturated, %0d errors",
             n_checked, n_clipped, n_err);
    if (n_err == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/mfd_pkg.sv
rtl/mfd_ram.sv
rtl/mfd_queue.sv
rtl/mfd_front.sv
rtl/mfd_back.sv
rtl/modulated_feedback_delay_unit.sv
verif/tb.sv
